>>> design/nmea_rmc_sentence_checker_unit_defines.svh
// Assertion macros shared by the NMEA RMC checker modules.
// No dependencies; included by the files that carry assertions.
`ifndef NMEA_RMC_SENTENCE_CHECKER_UNIT_DEFINES_SVH
`define NMEA_RMC_SENTENCE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NRMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nrmc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define NRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nrmc: next-cycle check failed");

`endif

>>> design/nrmc_pkg.sv
// Package for the NMEA RMC sentence checker: character codes, field numbers,
// the result word type and small decode functions. No dependencies.
`timescale 1ns / 1ps

package nrmc_pkg;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_D   = 8'h44;

	// Field numbers of interest (field 0 is the address)
	localparam logic [3:0] FLD_TIME   = 4'd1;
	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_DATE   = 4'd9;
	localparam logic [3:0] FLD_MODE   = 4'd12;
	localparam logic [3:0] FLD_SUM    = 4'd13;
	localparam logic [3:0] FLD_MAX    = 4'd15;

	// Character position limits
	localparam logic [3:0] POS_DIGITS  = 4'd6;
	localparam logic [3:0] POS_SUM_TOP = 4'd14;
	localparam logic [3:0] POS_MAX     = 4'd15;

	// Address characters collected before the lookup
	localparam logic [2:0] ADDR_LAST = 3'd4;

	// Sentence kinds, in lookup priority order
	localparam int ADDR_KINDS = 7;
	localparam logic [2:0] KIND_RMC  = 3'd0;
	localparam logic [2:0] KIND_NONE = 3'd7;
	localparam logic [23:0] ADDR_CODES [ADDR_KINDS] = '{
		"RMC", "VTG", "GGA", "GSA", "GLL", "GSV", "TXT"
	};

	localparam logic [23:0] NO_DIGITS = 24'hFFFFFF;

	// Result word handed from the parser to the output register
	typedef struct packed {
		logic        checksum_ok;
		logic        fix_valid;
		logic        time_valid;
		logic [23:0] time_bcd;
		logic [23:0] date_bcd;
	} rmc_result_t;

	// Hex digit decode: {valid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= "0" && b <= "9") begin
			r = {1'b1, b[3:0]};
		end else if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

	// Decimal digit as a nibble, 0xF when not a digit
	function automatic logic [3:0] digit_nibble(input logic [7:0] b);
		logic [3:0] r;
		r = 4'hF;
		if (b >= "0" && b <= "9") begin
			r = b[3:0];
		end
		return r;
	endfunction

	// True when all six nibbles are decimal digits
	function automatic logic all_decimal(input logic [23:0] v);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (v[4*k +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// Two BCD digits to binary: hi*10 + lo
	function automatic logic [6:0] bcd_pair(input logic [7:0] p);
		logic [6:0] hi;
		hi = {3'b000, p[7:4]};
		return 7'((hi << 3) + (hi << 1) + {3'b000, p[3:0]});
	endfunction

endpackage

>>> design/nrmc_parse.sv
// Per-byte sentence parser: address lookup, checksum, field split and
// time/date/status/mode capture. Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nrmc_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  logic [7:0]            rx_byte_s1,
	input  logic                  ready,
	output logic                  advance,
	output logic                  res_valid,
	output nrmc_pkg::rmc_result_t res
);
	import nrmc_pkg::*;

	typedef enum logic [1:0] {
		ADDR_COLLECT,
		ADDR_MATCHED,
		ADDR_REJECTED
	} addr_phase_t;

	// Lookup over all windows of the five address characters: {hit, kind}
	function automatic logic [3:0] addr_lookup(input logic [39:0] a);
		logic [3:0] r;
		r = {1'b0, KIND_NONE};
		for (int k = ADDR_KINDS - 1; k >= 0; k--) begin
			for (int w = 0; w < 3; w++) begin
				if (a[8*w +: 24] == ADDR_CODES[k]) begin
					r = {1'b1, 3'(k)};
				end
			end
		end
		return r;
	endfunction

	// Replace the nibble at one digit position (position 0 is the top nibble)
	function automatic logic [23:0] put_nibble(input logic [23:0] v,
		input logic [2:0] pos, input logic [3:0] d);
		logic [23:0] r;
		r = v;
		for (int j = 0; j < 6; j++) begin
			if (pos == 3'(j)) begin
				r[20 - 4*j +: 4] = d;
			end
		end
		return r;
	endfunction

	logic        in_sentence_q, in_sentence_n;
	addr_phase_t phase_q, phase_n;
	logic [39:0] addr_q, addr_n;
	logic [2:0]  addr_cnt_q, addr_cnt_n;
	logic [2:0]  kind_q, kind_n;
	logic [7:0]  xor_q, xor_n;
	logic        xor_active_q, xor_active_n;
	logic [3:0]  field_q, field_n;
	logic [3:0]  cif_q, cif_n;
	logic [7:0]  sum_q, sum_n;
	logic        too_wide_q, too_wide_n;
	logic [1:0]  flags_q, flags_n;
	logic [23:0] time_q, time_n;
	logic [23:0] date_q, date_n;
	logic [1:0]  ok_q, ok_n;

	logic        is_eol;
	logic        is_star;
	logic        sep;
	logic        emits;
	logic [4:0]  hex_d;
	logic [3:0]  dig;
	logic [39:0] addr_shift;
	logic [3:0]  lookup;
	logic [23:0] time_put;
	logic [23:0] date_put;

	// Byte classification and helpers
	assign is_eol     = (rx_byte_s1 == CH_CR) || (rx_byte_s1 == CH_LF);
	assign is_star    = (rx_byte_s1 == CH_STAR);
	assign sep        = (rx_byte_s1 == CH_COMMA) || (is_star && xor_active_q);
	assign hex_d      = hex_value(rx_byte_s1);
	assign dig        = digit_nibble(rx_byte_s1);
	assign addr_shift = {addr_q[31:0], rx_byte_s1};
	assign lookup     = addr_lookup(addr_shift);
	assign time_put   = put_nibble(time_q, cif_q[2:0], dig);
	assign date_put   = put_nibble(date_q, cif_q[2:0], dig);

	// A line end closing a matched RMC sentence produces a result word
	assign emits     = in_sentence_q && is_eol && (phase_q == ADDR_MATCHED)
		&& (kind_q == KIND_RMC);
	assign res_valid = valid_s1 && emits;
	assign advance   = valid_s1 && (!emits || ready);

	// Result word from the state held before the line end
	always_comb begin
		res.checksum_ok = !xor_active_q && (xor_q != 8'd0) && !too_wide_q
			&& (sum_q == xor_q);
		res.fix_valid   = (flags_q == 2'b11);
		res.time_valid  = (ok_q == 2'b11);
		res.time_bcd    = time_q;
		res.date_bcd    = date_q;
	end

	// Next state for one byte
	always_comb begin
		in_sentence_n = in_sentence_q;
		phase_n       = phase_q;
		addr_n        = addr_q;
		addr_cnt_n    = addr_cnt_q;
		kind_n        = kind_q;
		xor_n         = xor_q;
		xor_active_n  = xor_active_q;
		field_n       = field_q;
		cif_n         = cif_q;
		sum_n         = sum_q;
		too_wide_n    = too_wide_q;
		flags_n       = flags_q;
		time_n        = time_q;
		date_n        = date_q;
		ok_n          = ok_q;
		if (rx_byte_s1 == CH_DOLLAR) begin
			// Start a new sentence from a clean state
			in_sentence_n = 1'b1;
			phase_n       = ADDR_COLLECT;
			addr_n        = '0;
			addr_cnt_n    = '0;
			kind_n        = KIND_NONE;
			xor_n         = '0;
			xor_active_n  = 1'b1;
			field_n       = '0;
			cif_n         = '0;
			sum_n         = '0;
			too_wide_n    = 1'b0;
			flags_n       = '0;
			time_n        = NO_DIGITS;
			date_n        = NO_DIGITS;
			ok_n          = '0;
		end else if (rx_byte_s1 != CH_NUL && in_sentence_q) begin
			if (is_eol) begin
				in_sentence_n = 1'b0;
			end else begin
				// Checksum runs up to the first star
				if (is_star) begin
					xor_active_n = 1'b0;
				end else if (xor_active_q) begin
					xor_n = xor_q ^ rx_byte_s1;
				end
				// Address collection and lookup
				if (phase_q == ADDR_COLLECT) begin
					if (is_star) begin
						phase_n = ADDR_REJECTED;
					end else begin
						addr_n     = addr_shift;
						addr_cnt_n = addr_cnt_q + 3'd1;
						if (addr_cnt_q == ADDR_LAST) begin
							phase_n = lookup[3] ? ADDR_MATCHED : ADDR_REJECTED;
							kind_n  = lookup[2:0];
						end
					end
				end
				// Field split and field contents
				if (sep) begin
					if (field_q != FLD_MAX) begin
						field_n = field_q + 4'd1;
					end
					cif_n = '0;
				end else if (field_q == FLD_SUM) begin
					if (cif_q != POS_MAX) begin
						if (!hex_d[4]) begin
							cif_n = POS_MAX;
						end else begin
							if (sum_q[7:4] != 4'd0) begin
								too_wide_n = 1'b1;
							end
							sum_n = {sum_q[3:0], hex_d[3:0]};
							if (cif_q < POS_SUM_TOP) begin
								cif_n = cif_q + 4'd1;
							end
						end
					end
				end else begin
					if (field_q == FLD_TIME && cif_q < POS_DIGITS) begin
						time_n   = time_put;
						ok_n[0]  = all_decimal(time_put);
					end else if (field_q == FLD_DATE && cif_q < POS_DIGITS) begin
						date_n   = date_put;
						ok_n[1]  = all_decimal(date_put);
					end else if (field_q == FLD_STATUS) begin
						flags_n[0] = (cif_q == 4'd0) && (rx_byte_s1 == CH_UP_A);
					end else if (field_q == FLD_MODE) begin
						flags_n[1] = (cif_q == 4'd0)
							&& ((rx_byte_s1 == CH_UP_A) || (rx_byte_s1 == CH_UP_D));
					end
					if (cif_q != POS_MAX) begin
						cif_n = cif_q + 4'd1;
					end
				end
			end
		end
	end

	// Hold parser state; advance on each byte that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			phase_q       <= ADDR_COLLECT;
			addr_q        <= '0;
			addr_cnt_q    <= '0;
			kind_q        <= KIND_NONE;
			xor_q         <= '0;
			xor_active_q  <= 1'b0;
			field_q       <= '0;
			cif_q         <= '0;
			sum_q         <= '0;
			too_wide_q    <= 1'b0;
			flags_q       <= '0;
			time_q        <= '0;
			date_q        <= '0;
			ok_q          <= '0;
		end else if (advance) begin
			in_sentence_q <= in_sentence_n;
			phase_q       <= phase_n;
			addr_q        <= addr_n;
			addr_cnt_q    <= addr_cnt_n;
			kind_q        <= kind_n;
			xor_q         <= xor_n;
			xor_active_q  <= xor_active_n;
			field_q       <= field_n;
			cif_q         <= cif_n;
			sum_q         <= sum_n;
			too_wide_q    <= too_wide_n;
			flags_q       <= flags_n;
			time_q        <= time_n;
			date_q        <= date_n;
			ok_q          <= ok_n;
		end
	end

endmodule

>>> design/nrmc_out_reg.sv
// Output register: converts BCD digit pairs to binary and holds the result
// word until taken. Depends on nrmc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "nmea_rmc_sentence_checker_unit_defines.svh"

module nrmc_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  nrmc_pkg::rmc_result_t res,
	output logic                  ready,
	output logic                  valid,
	input  logic                  stall,
	output logic                  checksum_ok,
	output logic                  fix_valid,
	output logic                  time_valid,
	output logic [6:0]            utc_hours,
	output logic [6:0]            utc_minutes,
	output logic [6:0]            utc_seconds,
	output logic [6:0]            date_day,
	output logic [6:0]            date_month,
	output logic [6:0]            date_year
);
	import nrmc_pkg::*;

	logic       valid_q;
	logic       checksum_ok_q;
	logic       fix_valid_q;
	logic       time_valid_q;
	logic [6:0] hours_q, minutes_q, seconds_q;
	logic [6:0] day_q, month_q, year_q;
	logic       load;

	// Free when empty or when the held word is taken this cycle
	assign ready = !valid_q || !stall;
	assign load  = res_valid && ready;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= res_valid;
		end
	end

	// Capture the word; zero the digits when time or date is malformed
	always_ff @(posedge clk) begin
		if (load) begin
			checksum_ok_q <= res.checksum_ok;
			fix_valid_q   <= res.fix_valid;
			time_valid_q  <= res.time_valid;
			hours_q       <= res.time_valid ? bcd_pair(res.time_bcd[23:16]) : 7'd0;
			minutes_q     <= res.time_valid ? bcd_pair(res.time_bcd[15:8]) : 7'd0;
			seconds_q     <= res.time_valid ? bcd_pair(res.time_bcd[7:0]) : 7'd0;
			day_q         <= res.time_valid ? bcd_pair(res.date_bcd[23:16]) : 7'd0;
			month_q       <= res.time_valid ? bcd_pair(res.date_bcd[15:8]) : 7'd0;
			year_q        <= res.time_valid ? bcd_pair(res.date_bcd[7:0]) : 7'd0;
		end
	end

	assign valid       = valid_q;
	assign checksum_ok = checksum_ok_q;
	assign fix_valid   = fix_valid_q;
	assign time_valid  = time_valid_q;
	assign utc_hours   = hours_q;
	assign utc_minutes = minutes_q;
	assign utc_seconds = seconds_q;
	assign date_day    = day_q;
	assign date_month  = month_q;
	assign date_year   = year_q;

	`NRMC_ASSERT_NEXT(a_drain_empties, clk, arst_n, valid_q && !stall && !res_valid, !valid_q)
	`NRMC_ASSERT_IMPLY(a_bad_time_zero, clk, arst_n, valid_q && !time_valid_q, hours_q == 7'd0 && day_q == 7'd0 && year_q == 7'd0)

endmodule

>>> design/nmea_rmc_sentence_checker_unit.sv
// A line end enters the input register; its result word is loaded into the output register
// as the line end leaves the input register, and is held there until taken. Throughput:
// one byte per cycle; the input stalls only while a line end closing an RMC sentence waits
// behind a result word that is held stalled.
// Reset (arst_n low, asynchronous): no sentence open, both registers empty.
// Top level of the NMEA RMC checker. Depends on nrmc_pkg, nrmc_parse, nrmc_out_reg.
`timescale 1ns / 1ps
`include "nmea_rmc_sentence_checker_unit_defines.svh"

module nmea_rmc_sentence_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       checksum_ok,
	output logic       fix_valid,
	output logic       time_valid,
	output logic [6:0] utc_hours,
	output logic [6:0] utc_minutes,
	output logic [6:0] utc_seconds,
	output logic [6:0] date_day,
	output logic [6:0] date_month,
	output logic [6:0] date_year
);
	import nrmc_pkg::*;

	logic        s1_valid_q;
	logic [7:0]  rx_byte_s1;
	logic        advance;
	logic        ready;
	logic        res_valid;
	rmc_result_t res;
	logic        accept;

	// Input register: stall only while a held word cannot move on
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	nrmc_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (s1_valid_q),
		.rx_byte_s1 (rx_byte_s1),
		.ready      (ready),
		.advance    (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	nrmc_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.ready       (ready),
		.valid       (out_valid),
		.stall       (out_stall),
		.checksum_ok (checksum_ok),
		.fix_valid   (fix_valid),
		.time_valid  (time_valid),
		.utc_hours   (utc_hours),
		.utc_minutes (utc_minutes),
		.utc_seconds (utc_seconds),
		.date_day    (date_day),
		.date_month  (date_month),
		.date_year   (date_year)
	);

	`NRMC_ASSERT_IMPLY(a_stall_needs_full, clk, arst_n, in_stall, s1_valid_q && out_valid && out_stall)
	`NRMC_ASSERT_NEXT(a_accept_loads, clk, arst_n, accept, s1_valid_q)

endmodule

>>> bench/nmea_rmc_sentence_checker_unit_tb.sv
// Self-checking bench for nmea_rmc_sentence_checker_unit: feeds NMEA byte streams, predicts
// each RMC fix word in a small tracker class and compares every field. Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nmea_rmc_sentence_checker_unit_tb;
	import nrmc_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;
	localparam int ADDR_LEN      = 5;
	localparam int PHASE_BYTES   = 140;
	localparam int PHASE_FIXES   = 2;

	typedef enum logic [1:0] {ADDR_COLLECT, ADDR_MATCHED, ADDR_REJECTED} addr_state_t;
	typedef enum {SUM_GOOD, SUM_LOWER, SUM_BAD, SUM_NONE, SUM_WIDE, SUM_TRAIL} sum_form_t;
	typedef enum {END_CR, END_LF, END_CRLF, END_NONE} end_form_t;

	typedef struct packed {
		logic       checksum_ok;
		logic       fix_valid;
		logic       time_valid;
		logic [6:0] utc_hours;
		logic [6:0] utc_minutes;
		logic [6:0] utc_seconds;
		logic [6:0] date_day;
		logic [6:0] date_month;
		logic [6:0] date_year;
	} rmc_fix_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte     = 8'h00;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic       checksum_ok;
	logic       fix_valid;
	logic       time_valid;
	logic [6:0] utc_hours;
	logic [6:0] utc_minutes;
	logic [6:0] utc_seconds;
	logic [6:0] date_day;
	logic [6:0] date_month;
	logic [6:0] date_year;

	int          gap_pct    = 0;
	int          stall_pct  = 0;
	int          hold_req   = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;

	// Tracks the sentence parser and keeps the fix words still owed by the block
	class rmc_fix_book;
		rmc_fix_t    fixes_due[$];
		int unsigned fixes_total;
		int unsigned fixes_seen;
		int unsigned bad_fields;

		bit          open_line;
		addr_state_t addr_state;
		logic [39:0] addr_chars;
		int          addr_count;
		logic [2:0]  kind;
		logic [7:0]  line_xor;
		bit          xor_open;
		logic [3:0]  field_no;
		logic [3:0]  char_no;
		logic [7:0]  sum_seen;
		bit          sum_wide;
		logic [1:0]  fix_flags;
		logic [23:0] time_bcd;
		logic [23:0] date_bcd;
		logic [1:0]  digit_flags;

		function new();
			fixes_total = 0;
			fixes_seen  = 0;
			bad_fields  = 0;
			clear_line();
		endfunction

		function void clear_line();
			open_line   = 1'b0;
			addr_state  = ADDR_COLLECT;
			addr_chars  = '0;
			addr_count  = 0;
			kind        = KIND_NONE;
			line_xor    = 8'h00;
			xor_open    = 1'b0;
			field_no    = 4'd0;
			char_no     = 4'd0;
			sum_seen    = 8'h00;
			sum_wide    = 1'b0;
			fix_flags   = 2'b00;
			time_bcd    = '0;
			date_bcd    = '0;
			digit_flags = 2'b00;
		endfunction

		// Nibble 10..15 anywhere means the six positions are not all digits
		function bit six_digits(logic [23:0] v);
			bit ok;
			ok = 1'b1;
			for (int k = 0; k < 6; k++) begin
				if (v[4*k+3] && (v[4*k+2] || v[4*k+1])) begin
					ok = 1'b0;
				end
			end
			return ok;
		endfunction

		function logic [23:0] with_digit(logic [23:0] v, logic [3:0] pos, logic [7:0] b);
			logic [3:0] nib;
			nib = (b >= "0" && b <= "9") ? b[3:0] : 4'hF;
			v[23 - 4*pos -: 4] = nib;
			return v;
		endfunction

		function logic [6:0] pair_val(logic [7:0] p);
			return 7'(int'(p[7:4]) * 10 + int'(p[3:0]));
		endfunction

		// Search the three windows of the address, kinds in priority order
		function void lookup_address();
			addr_state = ADDR_REJECTED;
			for (int k = 0; k < ADDR_KINDS; k++) begin
				for (int w = 0; w < 3; w++) begin
					if (addr_state == ADDR_COLLECT || addr_state == ADDR_REJECTED) begin
						if (addr_chars[8*w +: 24] == ADDR_CODES[k]) begin
							addr_state = ADDR_MATCHED;
							kind = 3'(k);
						end
					end
				end
			end
		endfunction

		function void field_char(logic [7:0] b);
			int d;
			if (field_no == FLD_SUM) begin
				if (char_no == POS_MAX) begin
					return;
				end
				if (b >= "0" && b <= "9") d = b - "0";
				else if (b >= "A" && b <= "F") d = b - "A" + 10;
				else if (b >= "a" && b <= "f") d = b - "a" + 10;
				else d = -1;
				if (d < 0) begin
					char_no = POS_MAX;
					return;
				end
				if (sum_seen[7:4] != 4'h0) begin
					sum_wide = 1'b1;
				end
				sum_seen = {sum_seen[3:0], 4'(d)};
				if (char_no < POS_SUM_TOP) begin
					char_no = char_no + 4'd1;
				end
				return;
			end
			if (field_no == FLD_TIME && char_no < POS_DIGITS) begin
				time_bcd = with_digit(time_bcd, char_no, b);
				digit_flags[0] = six_digits(time_bcd);
			end else if (field_no == FLD_DATE && char_no < POS_DIGITS) begin
				date_bcd = with_digit(date_bcd, char_no, b);
				digit_flags[1] = six_digits(date_bcd);
			end else if (field_no == FLD_STATUS) begin
				fix_flags[0] = (char_no == 4'd0 && b == CH_UP_A);
			end else if (field_no == FLD_MODE) begin
				fix_flags[1] = (char_no == 4'd0 && (b == CH_UP_A || b == CH_UP_D));
			end
			if (char_no < POS_MAX) begin
				char_no = char_no + 4'd1;
			end
		endfunction

		// Advance the parser by one accepted byte; queue a fix word at the end of an RMC line
		function void take_byte(logic [7:0] b);
			bit       sep;
			rmc_fix_t fix;
			if (b == CH_NUL) begin
				return;
			end
			if (b == CH_DOLLAR) begin
				clear_line();
				open_line = 1'b1;
				xor_open  = 1'b1;
				time_bcd  = NO_DIGITS;
				date_bcd  = NO_DIGITS;
				return;
			end
			if (!open_line) begin
				return;
			end
			if (b == CH_CR || b == CH_LF) begin
				open_line = 1'b0;
				if (addr_state != ADDR_MATCHED || kind != KIND_RMC) begin
					return;
				end
				fix = '0;
				fix.checksum_ok = !xor_open && line_xor != 8'h00 && !sum_wide &&
					sum_seen == line_xor;
				fix.fix_valid  = (fix_flags == 2'b11);
				fix.time_valid = (digit_flags == 2'b11);
				if (fix.time_valid) begin
					fix.utc_hours   = pair_val(time_bcd[23:16]);
					fix.utc_minutes = pair_val(time_bcd[15:8]);
					fix.utc_seconds = pair_val(time_bcd[7:0]);
					fix.date_day    = pair_val(date_bcd[23:16]);
					fix.date_month  = pair_val(date_bcd[15:8]);
					fix.date_year   = pair_val(date_bcd[7:0]);
				end
				fixes_due.push_back(fix);
				fixes_total++;
				return;
			end

			sep = (b == CH_COMMA) || (b == CH_STAR && xor_open);
			if (b == CH_STAR) begin
				xor_open = 1'b0;
			end else if (xor_open) begin
				line_xor = line_xor ^ b;
			end

			if (addr_state == ADDR_COLLECT) begin
				if (b == CH_STAR) begin
					addr_state = ADDR_REJECTED;
				end else begin
					addr_chars = {addr_chars[31:0], b};
					addr_count++;
					if (addr_count == ADDR_LEN) begin
						lookup_address();
					end
				end
			end

			if (sep) begin
				if (field_no < FLD_MAX) begin
					field_no = field_no + 4'd1;
				end
				char_no = 4'd0;
			end else begin
				field_char(b);
			end
		endfunction

		task report(string what, int got, int want);
			$display("mismatch in %s of fix word %0d: got %0d, expected %0d",
				what, fixes_seen, got, want);
			bad_fields++;
		endtask

		// Compare one fix word from the block with the oldest one owed
		task check_fix(rmc_fix_t got);
			rmc_fix_t want;
			fixes_seen++;
			if (fixes_due.size() == 0) begin
				report("presence (no fix word owed)", 1, 0);
				return;
			end
			want = fixes_due.pop_front();
			if (got.checksum_ok !== want.checksum_ok)
				report("checksum_ok", got.checksum_ok, want.checksum_ok);
			if (got.fix_valid !== want.fix_valid)
				report("fix_valid", got.fix_valid, want.fix_valid);
			if (got.time_valid !== want.time_valid)
				report("time_valid", got.time_valid, want.time_valid);
			if (got.utc_hours !== want.utc_hours)
				report("utc_hours", got.utc_hours, want.utc_hours);
			if (got.utc_minutes !== want.utc_minutes)
				report("utc_minutes", got.utc_minutes, want.utc_minutes);
			if (got.utc_seconds !== want.utc_seconds)
				report("utc_seconds", got.utc_seconds, want.utc_seconds);
			if (got.date_day !== want.date_day)
				report("date_day", got.date_day, want.date_day);
			if (got.date_month !== want.date_month)
				report("date_month", got.date_month, want.date_month);
			if (got.date_year !== want.date_year)
				report("date_year", got.date_year, want.date_year);
		endtask
	endclass

	rmc_fix_book book = new();

	nmea_rmc_sentence_checker_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.checksum_ok (checksum_ok),
		.fix_valid   (fix_valid),
		.time_valid  (time_valid),
		.utc_hours   (utc_hours),
		.utc_minutes (utc_minutes),
		.utc_seconds (utc_seconds),
		.date_day    (date_day),
		.date_month  (date_month),
		.date_year   (date_year)
	);

	// Generate the clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Take fix words, stall at random, and hold off for a long stretch on request
	initial begin
		int       hold_left;
		rmc_fix_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.checksum_ok = checksum_ok;
				got.fix_valid   = fix_valid;
				got.time_valid  = time_valid;
				got.utc_hours   = utc_hours;
				got.utc_minutes = utc_minutes;
				got.utc_seconds = utc_seconds;
				got.date_day    = date_day;
				got.date_month  = date_month;
				got.date_year   = date_year;
				book.check_fix(got);
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one byte, hold it until it is taken, then hand it to the tracker
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		book.take_byte(b);
		bytes_sent++;
	endtask

	// Drop valid and wait until every owed fix word has come out
	task automatic wait_fixes_out();
		in_valid <= 1'b0;
		while (book.fixes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] xor_of(input string s);
		logic [7:0] x;
		int         i;
		x = 8'h00;
		for (i = 0; i < s.len(); i++) begin
			x = x ^ s[i];
		end
		return x;
	endfunction

	// Pad a line body so that its XOR comes to zero
	function automatic string zero_xor_text(input string s);
		logic [7:0] x;
		x = xor_of(s);
		if (x == CH_DOLLAR || x == CH_STAR || x == CH_COMMA || x == CH_CR || x == CH_LF) begin
			s = {s, "Z"};
			x = x ^ 8'h5A;
		end
		if (x != 8'h00) begin
			s = {s, $sformatf("%c", x)};
		end
		return s;
	endfunction

	function automatic string rmc_text(input string addr, input string tm, input string st,
			input string mid, input string dt, input string mag, input string md);
		return {addr, ",", tm, ",", st, ",", mid, ",", dt, ",", mag, ",", md};
	endfunction

	// Frame a body with the start mark, checksum and line end; optionally cut it short
	task automatic send_line(input string body, input sum_form_t form, input end_form_t term,
			input int nul_at, input int cut);
		string      text;
		logic [7:0] csum;
		int         n;
		int         i;
		csum = xor_of(body);
		text = {"$", body};
		case (form)
			SUM_GOOD:  text = {text, $sformatf("*%02X", csum)};
			SUM_LOWER: text = {text, $sformatf("*%02x", csum)};
			SUM_BAD:   text = {text, $sformatf("*%02X", csum ^ 8'($urandom_range(255, 1)))};
			SUM_WIDE:  text = {text, $sformatf("*1%02X", csum)};
			SUM_TRAIL: text = {text, $sformatf("*%02Xz,9*,,,,", csum)};
			default: ;
		endcase
		case (term)
			END_CR:   text = {text, "\r"};
			END_LF:   text = {text, "\n"};
			END_CRLF: text = {text, "\r\n"};
			default: ;
		endcase
		n = (cut >= 0 && cut < text.len()) ? cut : text.len();
		for (i = 0; i < n; i++) begin
			if (i == nul_at) begin
				send_byte(CH_NUL);
			end
			send_byte(text[i]);
		end
	endtask

	function automatic string rand_digits(input int n);
		string s;
		int    i;
		s = "";
		for (i = 0; i < n; i++) begin
			s = {s, $sformatf("%0d", $urandom_range(9))};
		end
		return s;
	endfunction

	// Any nonzero byte that does not frame or split a line
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255, 1));
		end while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	function automatic string rand_talker();
		int pick;
		pick = $urandom_range(3);
		if (pick == 0) return "GP";
		if (pick == 1) return "GN";
		return $sformatf("%c%c", 8'($urandom_range(CH_UP_A + 25, CH_UP_A)),
			8'($urandom_range(CH_UP_A + 25, CH_UP_A)));
	endfunction

	// Time or date field: mostly six digits, sometimes short, broken or empty
	function automatic string rand_clock_field();
		string f;
		int    pick;
		pick = $urandom_range(9);
		f = rand_digits(6);
		if (pick == 6) f = {f, ".", rand_digits($urandom_range(3))};
		else if (pick == 7) f = rand_digits($urandom_range(5));
		else if (pick == 8) f[$urandom_range(5)] = junk_char();
		else if (pick == 9) f = "";
		return f;
	endfunction

	function automatic string rand_flag_field(input string usual, input string other);
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) return usual;
		if (pick < 7) return other;
		if (pick == 7) return "N";
		if (pick == 8) return "";
		return {usual, $sformatf("%c", junk_char())};
	endfunction

	function automatic string rand_rmc_text();
		string mid;
		string addr;
		int    k;
		mid = "";
		for (k = 0; k < 6; k++) begin
			if (k > 0) mid = {mid, ","};
			if ($urandom_range(9) < 4) mid = {mid, rand_digits($urandom_range(5, 1))};
		end
		if ($urandom_range(9) == 0)
			addr = {$sformatf("%s", ADDR_CODES[KIND_RMC]), rand_talker()};
		else
			addr = {rand_talker(), $sformatf("%s", ADDR_CODES[KIND_RMC])};
		return rmc_text(addr, rand_clock_field(), rand_flag_field("A", "V"), mid,
			rand_clock_field(), ",", rand_flag_field("A", "D"));
	endfunction

	function automatic sum_form_t rand_sum_form();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65) return SUM_GOOD;
		if (pick < 75) return SUM_LOWER;
		if (pick < 85) return SUM_BAD;
		if (pick < 90) return SUM_NONE;
		if (pick < 95) return SUM_WIDE;
		return SUM_TRAIL;
	endfunction

	function automatic end_form_t rand_end_form();
		int pick;
		pick = $urandom_range(2);
		if (pick == 0) return END_CR;
		if (pick == 1) return END_LF;
		return END_CRLF;
	endfunction

	// One random line: mostly well-formed RMC, some other kinds, cut lines and noise
	task automatic send_random_line();
		int        pick;
		int        nul_at;
		sum_form_t form;
		end_form_t term;
		string     addr;
		pick   = $urandom_range(99);
		form   = rand_sum_form();
		term   = rand_end_form();
		nul_at = ($urandom_range(19) == 0) ? $urandom_range(30, 1) : -1;
		if (pick < 60) begin
			send_line(rand_rmc_text(), form, term, nul_at, -1);
		end else if (pick < 75) begin
			addr = {rand_talker(), $sformatf("%s", ADDR_CODES[$urandom_range(ADDR_KINDS - 1, 1)])};
			send_line({addr, ",", rand_digits($urandom_range(6)), ",A,",
				rand_digits($urandom_range(4))}, form, term, nul_at, -1);
		end else if (pick < 85) begin
			send_line(rand_rmc_text(), form, END_NONE, -1, $urandom_range(40, 1));
		end else if (pick < 92) begin
			repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
		end else begin
			case ($urandom_range(2))
				0: send_line({rand_talker(), "R*C,", rand_digits(6)}, form, term, -1, -1);
				1: send_line(rand_talker(), SUM_NONE, term, -1, -1);
				default: send_line(zero_xor_text(rand_rmc_text()), SUM_GOOD, term, -1, -1);
			endcase
		end
	endtask

	// Hand-picked lines: field extremes and each corner of the parser
	task automatic send_directed();
		string mid_full;
		string mid_none;
		mid_full = "4916.45,N,12311.12,W,000.5,054.7";
		mid_none = ",,,,,";
		// bytes outside any sentence
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(CH_NUL);
		send_byte(8'h7F);
		send_byte(CH_COMMA);
		send_byte(CH_LF);
		// clean fixes at the field extremes, CR LF ending gives one word
		send_line(rmc_text("GPRMC", "235959", "A", mid_full, "311299", "020.3,E", "A"),
			SUM_GOOD, END_CRLF, -1, -1);
		send_line(rmc_text("GNRMC", "999999.99", "A", mid_none, "999999", ",", "D"),
			SUM_LOWER, END_CR, -1, -1);
		send_line(rmc_text("GPRMC", "000000", "V", mid_none, "000000", ",", "N"),
			SUM_GOOD, END_LF, -1, -1);
		// checksum corners: wrong, absent, too wide, trailing junk, zero
		send_line(rmc_text("GPRMC", "120000", "A", mid_full, "010100", ",", "A"),
			SUM_BAD, END_CR, -1, -1);
		send_line(rmc_text("GPRMC", "081530", "A", mid_none, "150624", ",", "D"),
			SUM_NONE, END_CR, -1, -1);
		send_line(rmc_text("GPRMC", "081531", "A", mid_none, "150624", ",", "A"),
			SUM_WIDE, END_LF, -1, -1);
		send_line(rmc_text("GPRMC", "081532", "A", mid_none, "150624", ",", "A"),
			SUM_TRAIL, END_CR, -1, -1);
		send_line(zero_xor_text(rmc_text("GPRMC", "101010", "A", mid_none, "101010", ",", "A")),
			SUM_GOOD, END_CR, -1, -1);
		// address corners: late match, other kinds, no match, star, early line end
		send_line(rmc_text("RMCAB", "010203", "A", mid_none, "040506", ",", "A"),
			SUM_GOOD, END_CR, -1, -1);
		send_line("GPVTG,054.7,T,,M,005.5,N,010.2,K,A", SUM_GOOD, END_CRLF, -1, -1);
		send_line("GPTXT,01,01,02,ANTENNA OK", SUM_GOOD, END_CR, -1, -1);
		send_line(rmc_text("ABCDE", "010203", "A", mid_none, "040506", ",", "A"),
			SUM_GOOD, END_CR, -1, -1);
		send_line("GP*MC,123456,A", SUM_NONE, END_CR, -1, -1);
		send_line("GPR", SUM_NONE, END_CR, -1, -1);
		// new start mark inside a line restarts it
		send_line(rmc_text("GPRMC", "111111", "A", mid_none, "111111", ",", "A"),
			SUM_GOOD, END_NONE, -1, 14);
		send_line(rmc_text("GPRMC", "222222", "A", mid_none, "220222", ",", "A"),
			SUM_GOOD, END_CR, -1, -1);
		// NUL inside a line is dropped
		send_line(rmc_text("GPRMC", "131415", "A", mid_full, "161718", ",", "A"),
			SUM_GOOD, END_CR, 9, -1);
		// broken digits, status and mode not exactly one letter
		send_line(rmc_text("GPRMC", "12a456", "AV", mid_none, "0102", ",", "DA"),
			SUM_GOOD, END_CR, -1, -1);
	endtask

	// Run the stimulus and judge the outcome
	initial begin
		int ph;
		int goal_bytes;
		int goal_fixes;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 11;
		stall_pct = 57;
		send_directed();

		// hold off the output so the block backs up, then pause until it drains
		hold_req = HOLD_CYCLES;
		repeat (8) send_line("GPRMC", SUM_GOOD, END_CR, -1, -1);
		wait_fixes_out();

		for (ph = 0; ph < 3; ph++) begin
			gap_pct    = (ph == 0) ? 11 : (ph == 1) ? 57 : 0;
			stall_pct  = (ph == 0) ? 57 : (ph == 1) ? 11 : 0;
			goal_bytes = bytes_sent + PHASE_BYTES;
			goal_fixes = book.fixes_total + PHASE_FIXES;
			while (bytes_sent < goal_bytes || book.fixes_total < goal_fixes) begin
				send_random_line();
			end
		end

		wait_fixes_out();
		if (book.bad_fields == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
